/* design/wdm_pkg.sv */
package wdm_pkg;

    localparam int OFF_W      = 4;
    localparam int RESP_W     = 32;
    localparam int COEF_W     = 32;
    localparam int SCORE_W    = 40;
    localparam int SQ_W       = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int WIN_RADIUS = 4;

    typedef logic signed [OFF_W-1:0]   t_off;
    typedef logic signed [COEF_W-1:0]  t_coef;
    typedef logic signed [RESP_W-1:0]  t_resp;
    typedef logic signed [SCORE_W-1:0] t_score;

    localparam t_score SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_X_QUAD = 2'd0,
        CFG_X_LIN  = 2'd1,
        CFG_Y_QUAD = 2'd2,
        CFG_Y_LIN  = 2'd3
    } t_cfg_reg;

    // deformation products of one item, each already sign-extended to score width
    typedef struct packed {
        t_score x_quad;
        t_score x_lin;
        t_score y_quad;
        t_score y_lin;
    } t_terms;

    function automatic logic [SQ_W-1:0] off_square(t_off v);
        logic [SQ_W-1:0] sq;
        sq = '0;
        case (v)
            4'sh0: sq = 7'd0;
            4'sh1: sq = 7'd1;
            4'sh2: sq = 7'd4;
            4'sh3: sq = 7'd9;
            4'sh4: sq = 7'd16;
            4'sh5: sq = 7'd25;
            4'sh6: sq = 7'd36;
            4'sh7: sq = 7'd49;
            4'sh8: sq = 7'd64;
            4'sh9: sq = 7'd49;
            4'shA: sq = 7'd36;
            4'shB: sq = 7'd25;
            4'shC: sq = 7'd16;
            4'shD: sq = 7'd9;
            4'shE: sq = 7'd4;
            default: sq = 7'd1;
        endcase
        return sq;
    endfunction

    function automatic logic in_window(t_off v);
        return (int'(v) >= -WIN_RADIUS) && (int'(v) <= WIN_RADIUS);
    endfunction

endpackage

/* design/wdm_score.sv */
module wdm_score
    import wdm_pkg::*;
(
    input  t_off   i_off_x,
    input  t_off   i_off_y,
    input  t_coef  i_x_quad,
    input  t_coef  i_x_lin,
    input  t_coef  i_y_quad,
    input  t_coef  i_y_lin,
    output t_terms o_terms,
    output logic   o_inside
);

    logic signed [SQ_W:0]         sq_x;
    logic signed [SQ_W:0]         sq_y;
    logic signed [COEF_W+SQ_W:0]  xq_prod;
    logic signed [COEF_W+SQ_W:0]  yq_prod;
    logic signed [COEF_W+OFF_W-1:0] xl_prod;
    logic signed [COEF_W+OFF_W-1:0] yl_prod;

    assign sq_x = $signed({1'b0, off_square(i_off_x)});
    assign sq_y = $signed({1'b0, off_square(i_off_y)});

    assign xq_prod = i_x_quad * sq_x;
    assign yq_prod = i_y_quad * sq_y;
    assign xl_prod = i_x_lin * i_off_x;
    assign yl_prod = i_y_lin * i_off_y;

    assign o_terms.x_quad = SCORE_W'(xq_prod);
    assign o_terms.y_quad = SCORE_W'(yq_prod);
    assign o_terms.x_lin  = SCORE_W'(xl_prod);
    assign o_terms.y_lin  = SCORE_W'(yl_prod);

    assign o_inside = in_window(i_off_x) && in_window(i_off_y);

endmodule

/* design/windowed_deformation_max_top.sv */
// Windowed deformation max: finds the best deformed placement within one window.
// Input channel (i_in_valid / o_in_ready): one placement per item, carrying the
// offset from the probe, the Q16.16 response, a response-valid flag and a last
// flag closing the window. Output channel (o_out_valid / i_out_ready): one item
// per window, sent after the last placement, with the best Q24.16 score, its
// offsets and a found flag.
// Coefficients are written through i_cfg_we / i_cfg_idx / i_cfg_data while idle;
// the user must keep to this, as the block does not enforce it. Throughput: one
// item per cycle while o_in_ready is high. Four pipeline stages (input register,
// product register, score register, running max / output register) lie before
// each window's result; the running max compare-update is on the score stage.
// When the receiver stalls, the result waits in the output register while
// non-last items keep flowing; a following last item parks in the score stage
// and back-pressure reaches o_in_ready only once the stages behind it are full.
// Reset (synchronous, active low) clears the coefficients to zero, empties the
// pipeline and the output, and restarts the running maximum.
module windowed_deformation_max_top
    import wdm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_off                  i_off_x,
    input  t_off                  i_off_y,
    input  t_resp                 i_response,
    input  logic                  i_response_valid,
    input  logic                  i_last,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_score                o_best_score,
    output t_off                  o_best_off_x,
    output t_off                  o_best_off_y,
    output logic                  o_found,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_coef  r_x_quad, r_x_lin, r_y_quad, r_y_lin;

    logic   r_s1_valid, r_s1_resp_valid, r_s1_last;
    t_off   r_s1_off_x, r_s1_off_y;
    t_resp  r_s1_resp;

    logic   r_s2_valid, r_s2_elig, r_s2_last;
    t_off   r_s2_off_x, r_s2_off_y;
    t_resp  r_s2_resp;
    t_terms r_s2_terms;

    logic   r_s3_valid, r_s3_elig, r_s3_last;
    t_off   r_s3_off_x, r_s3_off_y;
    t_score r_s3_score;

    t_score r_run_max, n_run_max;
    t_off   r_run_off_x, n_run_off_x;
    t_off   r_run_off_y, n_run_off_y;
    logic   r_run_found, n_run_found;

    logic   r_out_valid, r_out_found;
    t_score r_out_score;
    t_off   r_out_off_x, r_out_off_y;

    t_terms s1_terms;
    logic   s1_inside;
    t_score s2_score;
    logic   out_free, s3_stall, s2_stall, s1_stall, s3_fire, out_load, take;

    wdm_score u_score (
        .i_off_x  (r_s1_off_x),
        .i_off_y  (r_s1_off_y),
        .i_x_quad (r_x_quad),
        .i_x_lin  (r_x_lin),
        .i_y_quad (r_y_quad),
        .i_y_lin  (r_y_lin),
        .o_terms  (s1_terms),
        .o_inside (s1_inside)
    );

    assign out_free   = !r_out_valid || i_out_ready;
    assign s3_stall   = r_s3_valid && r_s3_last && !out_free;
    assign s2_stall   = r_s2_valid && s3_stall;
    assign s1_stall   = r_s1_valid && s2_stall;
    assign o_in_ready = !s1_stall;
    assign s3_fire    = r_s3_valid && !s3_stall;
    assign out_load   = s3_fire && r_s3_last;

    assign s2_score = SCORE_W'(r_s2_resp) - r_s2_terms.x_quad - r_s2_terms.x_lin
                    - r_s2_terms.y_quad - r_s2_terms.y_lin;

    always_comb begin
        take        = r_s3_elig && (!r_run_found || (r_s3_score > r_run_max));
        n_run_max   = take ? r_s3_score : r_run_max;
        n_run_off_x = take ? r_s3_off_x : r_run_off_x;
        n_run_off_y = take ? r_s3_off_y : r_run_off_y;
        n_run_found = take || r_run_found;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_quad <= '0;
            r_x_lin  <= '0;
            r_y_quad <= '0;
            r_y_lin  <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_idx))
                CFG_X_QUAD: r_x_quad <= i_cfg_data;
                CFG_X_LIN:  r_x_lin  <= i_cfg_data;
                CFG_Y_QUAD: r_y_quad <= i_cfg_data;
                CFG_Y_LIN:  r_y_lin  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_run_max   <= SCORE_MIN;
            r_run_off_x <= '0;
            r_run_off_y <= '0;
            r_run_found <= 1'b0;
        end else begin
            if (!s1_stall) r_s1_valid <= i_in_valid;
            if (!s2_stall) r_s2_valid <= r_s1_valid;
            if (!s3_stall) r_s3_valid <= r_s2_valid;

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            if (s3_fire) begin
                if (r_s3_last) begin
                    r_run_max   <= SCORE_MIN;
                    r_run_off_x <= '0;
                    r_run_off_y <= '0;
                    r_run_found <= 1'b0;
                end else begin
                    r_run_max   <= n_run_max;
                    r_run_off_x <= n_run_off_x;
                    r_run_off_y <= n_run_off_y;
                    r_run_found <= n_run_found;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!s1_stall) begin
            r_s1_off_x      <= i_off_x;
            r_s1_off_y      <= i_off_y;
            r_s1_resp       <= i_response;
            r_s1_resp_valid <= i_response_valid;
            r_s1_last       <= i_last;
        end
        if (!s2_stall) begin
            r_s2_off_x <= r_s1_off_x;
            r_s2_off_y <= r_s1_off_y;
            r_s2_resp  <= r_s1_resp;
            r_s2_terms <= s1_terms;
            r_s2_elig  <= r_s1_resp_valid && s1_inside;
            r_s2_last  <= r_s1_last;
        end
        if (!s3_stall) begin
            r_s3_off_x <= r_s2_off_x;
            r_s3_off_y <= r_s2_off_y;
            r_s3_score <= s2_score;
            r_s3_elig  <= r_s2_elig;
            r_s3_last  <= r_s2_last;
        end
        if (out_load) begin
            r_out_score <= n_run_max;
            r_out_off_x <= n_run_off_x;
            r_out_off_y <= n_run_off_y;
            r_out_found <= n_run_found;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_best_score = r_out_score;
    assign o_best_off_x = r_out_off_x;
    assign o_best_off_y = r_out_off_y;
    assign o_found      = r_out_found;

endmodule

/* design/wdm_checker.sv */
module wdm_checker
    import wdm_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input t_score                o_best_score,
    input t_off                  o_best_off_x,
    input t_off                  o_best_off_y,
    input logic                  o_found
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output item valid right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_best_score)
            && $stable(o_best_off_x) && $stable(o_best_off_y) && $stable(o_found))
        else $error("stalled output item changed");

    a_not_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_found |-> o_best_score == SCORE_MIN
            && o_best_off_x == '0 && o_best_off_y == '0)
        else $error("empty window result not at reset values");

    a_found_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_found |-> in_window(o_best_off_x) && in_window(o_best_off_y))
        else $error("winning offset outside window");

endmodule

bind windowed_deformation_max_top wdm_checker u_wdm_checker (.*);

/* bench/windowed_deformation_max_top_tb.sv */
`timescale 1ns / 100ps

module windowed_deformation_max_top_tb;
    import wdm_pkg::*;

    typedef struct packed {
        t_off  off_x;
        t_off  off_y;
        t_resp response;
        logic  resp_ok;
        logic  win_last;
    } t_placement;

    typedef struct packed {
        t_score score;
        t_off   bx;
        t_off   by;
        logic   found;
    } t_window_best;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    t_off                  off_x = '0;
    t_off                  off_y = '0;
    t_resp                 response = '0;
    logic                  resp_ok = 1'b0;
    logic                  win_last = 1'b0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    t_score                best_score;
    t_off                  best_off_x;
    t_off                  best_off_y;
    logic                  found;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    t_placement   pending[$];
    t_window_best best_expected[$];

    // predictor copy of the coefficients and the running maximum
    t_coef  k_x_quad = '0;
    t_coef  k_x_lin = '0;
    t_coef  k_y_quad = '0;
    t_coef  k_y_lin = '0;
    t_score best_so_far = SCORE_MIN;
    t_off   best_dx = '0;
    t_off   best_dy = '0;
    logic   any_seen = 1'b0;

    logic in_acc = 1'b0;
    logic out_acc = 1'b0;
    int   in_gap = 0;
    bit   in_calm = 1'b0;
    int   out_wait = 0;
    bit   out_calm = 1'b0;

    int mismatch_count = 0;
    int placements_taken = 0;
    int placements_pushed = 0;
    int windows_closed = 0;
    int windows_found = 0;
    int coef_settings = 0;

    windowed_deformation_max_top dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (in_valid),
        .o_in_ready       (in_ready),
        .i_off_x          (off_x),
        .i_off_y          (off_y),
        .i_response       (response),
        .i_response_valid (resp_ok),
        .i_last           (win_last),
        .o_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .o_best_score     (best_score),
        .o_best_off_x     (best_off_x),
        .o_best_off_y     (best_off_y),
        .o_found          (found),
        .i_cfg_we         (cfg_we),
        .i_cfg_idx        (cfg_idx),
        .i_cfg_data       (cfg_data)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic bit inside_reach(t_off dx, t_off dy);
        return int'(dx) >= -WIN_RADIUS && int'(dx) <= WIN_RADIUS &&
               int'(dy) >= -WIN_RADIUS && int'(dy) <= WIN_RADIUS;
    endfunction

    function automatic t_score deformed_score(t_off dx, t_off dy, t_resp r);
        longint sx;
        longint sy;
        sx = longint'(dx);
        sy = longint'(dy);
        return t_score'(longint'(r)
                        - (longint'(k_x_quad) * sx * sx + longint'(k_x_lin) * sx)
                        - (longint'(k_y_quad) * sy * sy + longint'(k_y_lin) * sy));
    endfunction

    task automatic note_mismatch(string what, logic signed [63:0] want_v,
                                 logic signed [63:0] got_v);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("mismatch on %s: expected %0d, got %0d", what, want_v, got_v);
        end
    endtask

    always @(negedge i_clk) begin : feed
        t_placement nxt;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_acc) begin
            if (in_gap != 0) begin
                in_gap--;
                in_valid <= 1'b0;
            end else if (pending.size() != 0) begin
                nxt = pending.pop_front();
                off_x    <= nxt.off_x;
                off_y    <= nxt.off_y;
                response <= nxt.response;
                resp_ok  <= nxt.resp_ok;
                win_last <= nxt.win_last;
                in_valid <= 1'b1;
                if ($urandom_range(0, 39) == 0) in_calm = !in_calm;
                in_gap = in_calm ? 0 : $urandom_range(0, 8);
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin : sink
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_acc) begin
                if ($urandom_range(0, 19) == 0) out_calm = !out_calm;
                out_wait = out_calm ? 0 : $urandom_range(0, 8);
            end
            if (out_wait != 0) begin
                out_wait--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : watch
        t_score       s;
        t_window_best want;
        in_acc  <= i_rst_n && in_valid && in_ready;
        out_acc <= i_rst_n && out_valid && out_ready;
        if (i_rst_n && cfg_we) begin
            case (t_cfg_reg'(cfg_idx))
                CFG_X_QUAD: k_x_quad = t_coef'(cfg_data);
                CFG_X_LIN:  k_x_lin  = t_coef'(cfg_data);
                CFG_Y_QUAD: k_y_quad = t_coef'(cfg_data);
                CFG_Y_LIN:  k_y_lin  = t_coef'(cfg_data);
                default: ;
            endcase
        end
        if (i_rst_n && in_valid && in_ready) begin
            placements_taken++;
            if (resp_ok && inside_reach(off_x, off_y)) begin
                s = deformed_score(off_x, off_y, response);
                if (!any_seen || s > best_so_far) begin
                    best_so_far = s;
                    best_dx     = off_x;
                    best_dy     = off_y;
                    any_seen    = 1'b1;
                end
            end
            if (win_last) begin
                want.score = best_so_far;
                want.bx    = best_dx;
                want.by    = best_dy;
                want.found = any_seen;
                best_expected = {best_expected, want};
                windows_closed++;
                if (any_seen) windows_found++;
                best_so_far = SCORE_MIN;
                best_dx     = '0;
                best_dy     = '0;
                any_seen    = 1'b0;
            end
        end
        if (i_rst_n && out_valid && out_ready) begin
            if (best_expected.size() == 0) begin
                note_mismatch("unexpected result, best_score", 0, best_score);
            end else begin
                want = best_expected.pop_front();
                if (best_score !== want.score)
                    note_mismatch("best_score", want.score, best_score);
                if (best_off_x !== want.bx)
                    note_mismatch("best_off_x", want.bx, best_off_x);
                if (best_off_y !== want.by)
                    note_mismatch("best_off_y", want.by, best_off_y);
                if (found !== want.found)
                    note_mismatch("found", want.found, found);
            end
        end
    end

    task automatic push_item(t_off dx, t_off dy, t_resp r, bit ok, bit lst);
        t_placement p;
        p.off_x    = dx;
        p.off_y    = dy;
        p.response = r;
        p.resp_ok  = ok;
        p.win_last = lst;
        pending = {pending, p};
        placements_pushed++;
    endtask

    // all items accepted and all results back, followed by idle slack
    task automatic settle();
        do @(posedge i_clk); while (pending.size() != 0 || in_valid);
        while (best_expected.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_coefs(t_coef xq, t_coef xl, t_coef yq, t_coef yl);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_X_QUAD;
        cfg_data <= xq;
        @(negedge i_clk);
        cfg_idx  <= CFG_X_LIN;
        cfg_data <= xl;
        @(negedge i_clk);
        cfg_idx  <= CFG_Y_QUAD;
        cfg_data <= yq;
        @(negedge i_clk);
        cfg_idx  <= CFG_Y_LIN;
        cfg_data <= yl;
        @(negedge i_clk);
        cfg_we   <= 1'b0;
        coef_settings++;
    endtask

    function automatic t_resp pick_resp();
        case ($urandom_range(0, 7))
            0:       return 32'sh7FFFFFFF;
            1:       return 32'sh80000000;
            2, 3:    return t_resp'((int'($urandom_range(0, 6)) - 3) * 65536);
            default: return t_resp'($urandom);
        endcase
    endfunction

    function automatic t_coef pick_coef();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return 32'sh7FFFFFFF;
            2:       return 32'sh80000000;
            3:       return t_coef'((int'($urandom_range(0, 8)) - 4) * 16384);
            default: return t_coef'($urandom);
        endcase
    endfunction

    task automatic push_window();
        int kind;
        int rx;
        int ry;
        int n;
        kind = $urandom_range(0, 9);
        if (kind < 7) begin
            // column-major sweep of a sub-window
            rx = ($urandom_range(0, 7) == 0) ? WIN_RADIUS : $urandom_range(0, 2);
            ry = ($urandom_range(0, 7) == 0) ? WIN_RADIUS : $urandom_range(0, 2);
            for (int dx = rx; dx >= -rx; dx--) begin
                for (int dy = ry; dy >= -ry; dy--) begin
                    push_item(t_off'(dx), t_off'(dy), pick_resp(),
                              $urandom_range(0, 7) != 0, dx == -rx && dy == -ry);
                end
            end
        end else begin
            // noise: any offsets, possibly nothing valid
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++) begin
                push_item(t_off'($urandom_range(0, 15)), t_off'($urandom_range(0, 15)),
                          pick_resp(), kind == 9 ? 1'b0 : 1'($urandom_range(0, 1)),
                          i == n - 1);
            end
        end
    endtask

    initial begin : stimulus
        int next_switch;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // coefficients at reset value zero
        push_item(t_off'(0), t_off'(0), 32'sh00050000, 1'b1, 1'b1);
        push_item(t_off'(3), t_off'(-3), 32'sh00020000, 1'b1, 1'b0);
        push_item(t_off'(-1), t_off'(2), 32'sh00020000, 1'b1, 1'b1);
        push_item(t_off'(1), t_off'(1), 32'sh00000007, 1'b0, 1'b0);
        push_item(t_off'(-2), t_off'(3), 32'sh7FFFFFFF, 1'b0, 1'b1);
        push_item(t_off'(-5), t_off'(0), 32'sh7FFFFFFF, 1'b1, 1'b0);
        push_item(t_off'(5), t_off'(1), 32'sh7FFFFFFF, 1'b1, 1'b0);
        push_item(t_off'(0), t_off'(-8), 32'sh7FFFFFFF, 1'b1, 1'b0);
        push_item(t_off'(7), t_off'(7), 32'sh7FFFFFFF, 1'b1, 1'b0);
        push_item(t_off'(-4), t_off'(4), 32'sh80000000, 1'b1, 1'b1);
        push_item(t_off'(6), t_off'(0), 32'sh00010000, 1'b1, 1'b1);
        settle();

        write_coefs(32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF);
        push_item(t_off'(4), t_off'(-4), 32'sh7FFFFFFF, 1'b1, 1'b0);
        push_item(t_off'(-4), t_off'(4), 32'sh80000000, 1'b1, 1'b0);
        push_item(t_off'(4), t_off'(4), 32'sh7FFFFFFF, 1'b1, 1'b0);
        push_item(t_off'(-4), t_off'(-4), 32'sh80000000, 1'b1, 1'b1);
        push_item(t_off'(0), t_off'(0), 32'sh80000000, 1'b1, 1'b1);
        push_item(t_off'(1), t_off'(-1), 32'sh00001234, 1'b1, 1'b0);
        push_item(t_off'(2), t_off'(2), 32'sh00000000, 1'b0, 1'b1);
        settle();

        write_coefs(32'sh00010000, 32'sh00008000, 32'sh00020000, -32'sh00010000);
        push_item(t_off'(-1), t_off'(0), 32'sh00000000, 1'b1, 1'b0);
        push_item(t_off'(1), t_off'(0), 32'sh00000000, 1'b1, 1'b0);
        push_item(t_off'(0), t_off'(1), 32'sh00000000, 1'b1, 1'b0);
        push_item(t_off'(0), t_off'(-1), 32'sh00000000, 1'b1, 1'b1);
        push_item(t_off'(0), t_off'(0), 32'sh7FFFFFFF, 1'b0, 1'b1);

        placements_pushed = 0;
        next_switch = 0;
        while (placements_pushed < 800) begin
            if (placements_pushed >= next_switch) begin
                settle();
                write_coefs(pick_coef(), pick_coef(), pick_coef(), pick_coef());
                next_switch += 120;
            end
            push_window();
        end
        settle();

        $display("covered %0d placements in %0d windows, %0d with a valid placement",
                 placements_taken, windows_closed, windows_found);
        $display("across %0d coefficient settings, %0d mismatches",
                 coef_settings, mismatch_count);
        if (mismatch_count == 0 && best_expected.size() == 0) begin
            $display("windowed_deformation_max_top_tb: done, clean");
        end else begin
            $display("windowed_deformation_max_top_tb: done, errors");
        end
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("windowed_deformation_max_top_tb: done, errors");
        $finish;
    end

endmodule
